// ===== design/ola_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ola_pkg: shared types and constants for the ordered array list engine
// Holds the store geometry, the word structs of both channels, the mode and
// status codes, the controller states and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ola_pkg;

  localparam int DEPTH     = 256;
  localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int LEAVES    = 1 << IDX_BITS;
  // compare width that holds a position, a count and a capacity register value
  localparam int CMP_BITS  = (CNT_BITS > 9) ? CNT_BITS : 9;
  localparam int DATA_BITS = 32;

  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_GET    = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_EDIT   = 3'd4;
  localparam logic [2:0] MODE_SEARCH = 3'd5;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]                  mode;
    logic [7:0]                  position;
    logic signed [DATA_BITS-1:0] word;
  } req_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [DATA_BITS-1:0] read_word;
    logic                        found;
    logic [7:0]                  found_position;
    logic [8:0]                  entry_count;
    logic [8:0]                  current_capacity;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic                  probe;
    logic                  search;
    logic [IDX_BITS-1:0]   pos;
    logic [DATA_BITS-1:0]  key;
    logic [CNT_BITS-1:0]   count;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/ola_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ola_cell: one entry of the list store
// Holds one word, takes its left or right neighbor on insert and delete
// shifts, and registers a hit flag for position or value matches.
// ----------------------------------------------------------------------------
module ola_cell (
  input  wire logic                          clk,
  input  wire logic [ola_pkg::IDX_BITS-1:0]  idx,
  input  wire ola_pkg::cell_ctrl_t           ctrl,
  input  wire logic [ola_pkg::DATA_BITS-1:0] prev_data,
  input  wire logic [ola_pkg::DATA_BITS-1:0] next_data,
  output logic      [ola_pkg::DATA_BITS-1:0] data,
  output logic                               hit
);

  logic [ola_pkg::DATA_BITS-1:0] data_next;
  logic                          hit_next;
  logic                          at_pos;
  logic                          above_pos;

  assign at_pos    = (idx == ctrl.pos);
  assign above_pos = (idx > ctrl.pos);

  always_comb begin
    data_next = data;
    case (ctrl.op)
      ola_pkg::CELL_WRITE: begin
        if (at_pos) data_next = ctrl.key;
      end
      ola_pkg::CELL_INSERT: begin
        if (above_pos)   data_next = prev_data;
        else if (at_pos) data_next = ctrl.key;
      end
      ola_pkg::CELL_DELETE: begin
        if (above_pos || at_pos) data_next = next_data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // value match only counts for live entries
  assign hit_next = ctrl.search
                  ? ((ola_pkg::CNT_BITS'(idx) < ctrl.count) && (data == ctrl.key))
                  : at_pos;

  always_ff @(posedge clk) begin
    data <= data_next;
    if (ctrl.probe) hit <= hit_next;
  end

endmodule
`default_nettype wire

// ===== design/ola_pick.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ola_pick: first-hit reduction over the cell row
// Balanced tree that finds the lowest flagged cell and ORs the flagged words.
// ----------------------------------------------------------------------------
module ola_pick (
  input  wire logic [ola_pkg::DEPTH-1:0]     hits,
  input  wire logic [ola_pkg::DATA_BITS-1:0] words [ola_pkg::DEPTH],
  output logic                               any_hit,
  output logic      [ola_pkg::IDX_BITS-1:0]  first_idx,
  output logic      [ola_pkg::DATA_BITS-1:0] hit_word
);

  localparam int NODES = 2 * ola_pkg::LEAVES;

  logic                          node_v [NODES];
  logic [ola_pkg::IDX_BITS-1:0]  node_i [NODES];
  logic [ola_pkg::DATA_BITS-1:0] node_w [NODES];

  always_comb begin
    node_v[0] = 1'b0;
    node_i[0] = '0;
    node_w[0] = '0;
    for (int k = 0; k < ola_pkg::LEAVES; k++) begin
      if (k < ola_pkg::DEPTH) begin
        node_v[ola_pkg::LEAVES + k] = hits[k];
        node_w[ola_pkg::LEAVES + k] = hits[k] ? words[k] : '0;
      end else begin
        node_v[ola_pkg::LEAVES + k] = 1'b0;
        node_w[ola_pkg::LEAVES + k] = '0;
      end
      node_i[ola_pkg::LEAVES + k] = ola_pkg::IDX_BITS'(k);
    end
    // left child always carries the lower index: prefer it
    for (int n = ola_pkg::LEAVES - 1; n >= 1; n--) begin
      node_v[n] = node_v[2*n] | node_v[2*n+1];
      node_i[n] = node_v[2*n] ? node_i[2*n] : node_i[2*n+1];
      node_w[n] = node_w[2*n] | node_w[2*n+1];
    end
  end

  assign any_hit   = node_v[1];
  assign first_idx = node_i[1];
  assign hit_word  = node_w[1];

endmodule
`default_nettype wire

// ===== design/ordered_array_list_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_array_list_engine_core: positional list of signed words
// A row of cells holds the list; insert and delete shift the whole row in
// one commit, get and search flag cells in parallel and a reduction tree picks
// the first flagged entry. Capacity grows by doubling and shrinks by halving.
//
//   channel  signals                           direction  handshake
//   req      req_valid / req_ready / req       in         valid-ready
//   rsp      rsp_valid / rsp_ready / rsp       out        valid-ready
//   cfg      cfg_wr_en / cfg_wr_data           in         write, no wait
//
// Each word passes through two states: EVAL registers the per-cell hit flags,
// COMMIT reduces them and commits the shift. The commit also accepts the next
// word, so a new word is taken only as the previous one commits.
// A stalled rsp channel holds the commit cycle until the output register frees.
// Reset clears count and capacity; the store contents stay undefined.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ola_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output ola_pkg::rsp_t      rsp,
  input  wire logic          cfg_wr_en,
  input  wire logic [8:0]    cfg_wr_data
);

  localparam int CB = ola_pkg::CNT_BITS;
  localparam int MB = ola_pkg::CMP_BITS;
  localparam int IB = ola_pkg::IDX_BITS;

  ola_pkg::state_t state, state_next;
  ola_pkg::req_t   item;
  logic [CB-1:0]   count, count_next;
  logic [CB-1:0]   cap, cap_next;

  logic probe;
  logic commit_go;

  // cell row wiring
  ola_pkg::cell_ctrl_t           ctrl;
  logic [ola_pkg::DATA_BITS-1:0] cell_data [ola_pkg::DEPTH];
  logic [ola_pkg::DATA_BITS-1:0] prev_arr  [ola_pkg::DEPTH];
  logic [ola_pkg::DATA_BITS-1:0] next_arr  [ola_pkg::DEPTH];
  logic [ola_pkg::DEPTH-1:0]     cell_hit;

  logic                          any_hit;
  logic [IB-1:0]                 first_idx;
  logic [ola_pkg::DATA_BITS-1:0] hit_word;

  // commit decisions
  ola_pkg::cell_op_t op;
  logic [IB-1:0]     op_pos;
  ola_pkg::rsp_t     result;

  logic [MB-1:0] pos_ext, cnt_ext, cap_ext, cfg_ext;
  logic          grow, at_depth, cap_zero;
  logic [CB:0]   cap_dbl;
  logic [CB-1:0] cap_grown;
  logic [CB-1:0] cnt_dec;

  // ---- state machine --------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ola_pkg::ST_IDLE: begin
        if (req_valid) state_next = ola_pkg::ST_EVAL;
      end
      ola_pkg::ST_EVAL: begin
        state_next = ola_pkg::ST_COMMIT;
      end
      ola_pkg::ST_COMMIT: begin
        if (commit_go) state_next = req_valid ? ola_pkg::ST_EVAL : ola_pkg::ST_IDLE;
      end
      default: begin
        state_next = ola_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    probe     = 1'b0;
    commit_go = 1'b0;
    req_ready = 1'b0;
    case (state)
      ola_pkg::ST_IDLE: begin
        req_ready = 1'b1;
      end
      ola_pkg::ST_EVAL: begin
        probe = 1'b1;
      end
      ola_pkg::ST_COMMIT: begin
        // commit only when the output register can take the result
        commit_go = !rsp_valid || rsp_ready;
        req_ready = commit_go;
      end
      default: begin
        probe = 1'b0;
      end
    endcase
  end

  // ---- operation decode -----------------------------------------------------
  assign pos_ext   = MB'(item.position);
  assign cnt_ext   = MB'(count);
  assign cap_ext   = MB'(cap);
  assign cfg_ext   = MB'(cfg_wr_data);
  assign cap_zero  = (cap == '0);
  assign grow      = (cnt_ext >= cap_ext);
  assign at_depth  = (cnt_ext >= MB'(ola_pkg::DEPTH));
  assign cap_dbl   = {cap, 1'b0};
  assign cap_grown = (cap_dbl > (CB+1)'(ola_pkg::DEPTH)) ? CB'(ola_pkg::DEPTH)
                                                         : CB'(cap_dbl);
  assign cnt_dec   = count - CB'(1);

  always_comb begin
    op                      = ola_pkg::CELL_HOLD;
    op_pos                  = IB'(item.position);
    count_next              = count;
    cap_next                = cap;
    result.status           = ola_pkg::STATUS_OK;
    result.read_word        = '0;
    result.found            = 1'b0;
    result.found_position   = '0;
    case (item.mode)
      ola_pkg::MODE_APPEND, ola_pkg::MODE_INSERT: begin
        if (cap_zero) begin
          result.status = ola_pkg::STATUS_UNDERFLOW;
        end else if (item.mode == ola_pkg::MODE_INSERT && pos_ext > cnt_ext) begin
          result.status = ola_pkg::STATUS_BAD_INDEX;
        end else if (grow && at_depth) begin
          result.status = ola_pkg::STATUS_FULL;
        end else begin
          op         = ola_pkg::CELL_INSERT;
          // append lands just past the last entry
          if (item.mode == ola_pkg::MODE_APPEND) op_pos = IB'(count);
          count_next = count + CB'(1);
          if (grow) cap_next = cap_grown;
        end
      end
      ola_pkg::MODE_GET: begin
        if (pos_ext >= cnt_ext) result.status = ola_pkg::STATUS_BAD_INDEX;
        else                    result.read_word = hit_word;
      end
      ola_pkg::MODE_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          result.status = ola_pkg::STATUS_BAD_INDEX;
        end else begin
          result.read_word = hit_word;
          op               = ola_pkg::CELL_DELETE;
          count_next       = cnt_dec;
          if (cnt_dec == (cap >> 1)) cap_next = cap >> 1;
        end
      end
      ola_pkg::MODE_EDIT: begin
        if (pos_ext >= cnt_ext) result.status = ola_pkg::STATUS_BAD_INDEX;
        else                    op = ola_pkg::CELL_WRITE;
      end
      ola_pkg::MODE_SEARCH: begin
        result.found = any_hit;
        if (any_hit) result.found_position = 8'(first_idx);
      end
      default: begin
        op = ola_pkg::CELL_HOLD;
      end
    endcase
    result.entry_count      = 9'(count_next);
    result.current_capacity = 9'(cap_next);
  end

  // ---- cell row -------------------------------------------------------------
  assign ctrl.op     = commit_go ? op : ola_pkg::CELL_HOLD;
  assign ctrl.probe  = probe;
  assign ctrl.search = (item.mode == ola_pkg::MODE_SEARCH);
  assign ctrl.pos    = op_pos;
  assign ctrl.key    = item.word;
  assign ctrl.count  = count;

  for (genvar g = 0; g < ola_pkg::DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_arr[g] = '0;
    end else begin : g_mid
      assign prev_arr[g] = cell_data[g-1];
    end
    if (g == ola_pkg::DEPTH - 1) begin : g_last
      assign next_arr[g] = '0;
    end else begin : g_inner
      assign next_arr[g] = cell_data[g+1];
    end

    ola_cell u_cell (
      .clk       (clk),
      .idx       (IB'(g)),
      .ctrl      (ctrl),
      .prev_data (prev_arr[g]),
      .next_data (next_arr[g]),
      .data      (cell_data[g]),
      .hit       (cell_hit[g])
    );
  end

  ola_pick u_pick (
    .hits      (cell_hit),
    .words     (cell_data),
    .any_hit   (any_hit),
    .first_idx (first_idx),
    .hit_word  (hit_word)
  );

  // ---- registers ------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ola_pkg::ST_IDLE;
      count     <= '0;
      cap       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        // new list: clamp capacity to the store, drop all entries
        cap   <= (cfg_ext > MB'(ola_pkg::DEPTH)) ? CB'(ola_pkg::DEPTH) : CB'(cfg_wr_data);
        count <= '0;
      end else if (commit_go) begin
        cap   <= cap_next;
        count <= count_next;
      end
      if (commit_go)      rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // hold the item and result words; no reset needed
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) item <= req;
    if (commit_go)              rsp  <= result;
  end

endmodule
`default_nettype wire
